>>> hdl/ps2md_pkg.sv
// Shared types, constants and codes for the PS/2 mouse packet decoder.
// No dependencies; every other file imports this package.
package ps2md_pkg;

    // Cursor coordinate width. The screen limits clamp to 1..2**COORD_BITS.
    localparam int COORD_BITS = 12;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd768;

    // Clamp arithmetic widths
    localparam int LIM_W     = COORD_BITS + 1;
    localparam int LIM_CMP_W = (CFG_W > LIM_W) ? CFG_W : LIM_W;
    localparam int SUM_W     = COORD_BITS + 2;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = 2 * COORD_BITS + 38;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        FMT_STD   = 2'd0,
        FMT_WHEEL = 2'd1,
        FMT_FIVE  = 2'd2,
        FMT_NONE  = 2'd3
    } fmt_t;

    // Wheel step encodings (2-bit two's complement)
    localparam logic [1:0] WHEEL_ZERO = 2'b00;
    localparam logic [1:0] WHEEL_POS  = 2'b01;
    localparam logic [1:0] WHEEL_NEG  = 2'b11;

    // First-byte check: bit 3 set, overflow bits clear
    localparam logic [7:0] HDR_MASK  = 8'hC8;
    localparam logic [7:0] HDR_MATCH = 8'h08;

    // Five-button format, low nibble of the fourth byte
    localparam logic [3:0] NIB_NONE  = 4'h0;
    localparam logic [3:0] NIB_UP    = 4'h1;
    localparam logic [3:0] NIB_DOWN  = 4'hF;
    localparam logic [3:0] NIB_RIGHT = 4'h2;
    localparam logic [3:0] NIB_LEFT  = 4'hE;

    // One classified packet, front to back
    typedef struct packed {
        logic signed [8:0] move_x;
        logic signed [9:0] move_y;     // already negated
        logic [2:0]        low_btn;    // left, middle, right
        logic [1:0]        high_btn;   // fourth, fifth
        logic              keep_high;  // keep stored fourth/fifth state
        logic [1:0]        wheel_v;
        logic [1:0]        wheel_h;
    } pkt_t;

endpackage

>>> hdl/ps2md_front.sv
// Byte assembler: checks the first byte, gathers 3- or 4-byte packets and
// classifies them into pkt_t records. Depends on ps2md_pkg.
module ps2md_front
    import ps2md_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic accept,
    input  logic [7:0] data_byte,
    input  fmt_t fmt,
    output logic push,
    output pkt_t rec
);

    logic [1:0] count_reg, count_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;

    logic [7:0] src2;
    logic [9:0] my_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

    always_comb begin
        count_next = count_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        push       = 1'b0;

        // In the standard format the third byte comes straight off the input.
        src2   = (fmt == FMT_STD) ? data_byte : b2_reg;
        my_raw = {b0_reg[5], b0_reg[5], src2};

        rec.move_x    = {b0_reg[4], b1_reg};
        rec.move_y    = ~my_raw + 10'd1;
        rec.low_btn   = {b0_reg[1], b0_reg[2], b0_reg[0]};
        rec.high_btn  = 2'b00;
        rec.keep_high = 1'b1;
        rec.wheel_v   = WHEEL_ZERO;
        rec.wheel_h   = WHEEL_ZERO;

        if (accept) begin
            if (fmt == FMT_NONE) begin
                count_next = 2'd0;
            end else begin
                case (count_reg)
                    2'd0: begin
                        if ((data_byte & HDR_MASK) == HDR_MATCH) begin
                            b0_next    = data_byte;
                            count_next = 2'd1;
                        end
                    end
                    2'd1: begin
                        b1_next    = data_byte;
                        count_next = 2'd2;
                    end
                    default: begin
                        if (fmt == FMT_STD) begin
                            b2_next    = data_byte;
                            count_next = 2'd0;
                            push       = 1'b1;
                        end else if (count_reg == 2'd2) begin
                            b2_next    = data_byte;
                            count_next = 2'd3;
                        end else begin
                            count_next = 2'd0;
                            if (fmt == FMT_WHEEL) begin
                                push = 1'b1;
                                if (data_byte != 8'd0) begin
                                    rec.wheel_v = data_byte[7] ? WHEEL_NEG : WHEEL_POS;
                                end
                            end else if (data_byte[7:6] == 2'b00) begin
                                rec.keep_high = 1'b0;
                                rec.high_btn  = {data_byte[5], data_byte[4]};
                                case (data_byte[3:0])
                                    NIB_NONE:  push = 1'b1;
                                    NIB_UP: begin
                                        push        = 1'b1;
                                        rec.wheel_v = WHEEL_POS;
                                    end
                                    NIB_DOWN: begin
                                        push        = 1'b1;
                                        rec.wheel_v = WHEEL_NEG;
                                    end
                                    NIB_RIGHT: begin
                                        push        = 1'b1;
                                        rec.wheel_h = WHEEL_POS;
                                    end
                                    NIB_LEFT: begin
                                        push        = 1'b1;
                                        rec.wheel_h = WHEEL_NEG;
                                    end
                                    default: push = 1'b0;
                                endcase
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/ps2md_queue.sv
// Short FIFO of classified packets between the front and back halves.
// Depends on ps2md_pkg.
module ps2md_queue
    import ps2md_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  pkt_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output pkt_t pop_data
);

    pkt_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/ps2md_back.sv
// Packet executor: updates button and cursor state per packet and holds the
// result beat in an output register. Depends on ps2md_pkg.
module ps2md_back
    import ps2md_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic [CFG_W-1:0] screen_width,
    input  logic [CFG_W-1:0] screen_height,
    input  logic q_valid,
    input  pkt_t q_data,
    output logic q_pop,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(RESET_WIDTH >> 1);
    localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(RESET_HEIGHT >> 1);

    function automatic logic [LIM_W-1:0] eff_limit(input logic [CFG_W-1:0] r);
        logic [LIM_CMP_W-1:0] rx;
        rx = LIM_CMP_W'(r);
        if (rx == '0) begin
            return LIM_W'(1);
        end else if (rx > (LIM_CMP_W'(1) << COORD_BITS)) begin
            return LIM_W'(1) << COORD_BITS;
        end else begin
            return rx[LIM_W-1:0];
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(input logic [COORD_BITS-1:0] pos,
                                                     input logic signed [9:0] mv,
                                                     input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] slim;
        v    = $signed({2'b00, pos}) + SUM_W'(mv);
        slim = $signed({1'b0, lim});
        if (v < 0) begin
            return '0;
        end else if (v >= slim) begin
            return COORD_BITS'(lim - 1'b1);
        end else begin
            return v[COORD_BITS-1:0];
        end
    endfunction

    logic                  m_tvalid_reg;
    logic [4:0]            held_reg;
    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;

    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [8:0]            mx_reg;
    logic [9:0]            my_reg;
    logic [4:0]            o_held_reg, o_press_reg, o_rel_reg;
    logic [1:0]            wv_reg, wh_reg;

    logic [4:0]            held_next;
    logic [COORD_BITS-1:0] pos_x_next, pos_y_next;

    assign q_pop = q_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        held_next[2:0] = q_data.low_btn;
        held_next[4:3] = q_data.keep_high ? held_reg[4:3] : q_data.high_btn;
        pos_x_next = clamp(pos_x_reg, 10'(q_data.move_x), eff_limit(screen_width));
        pos_y_next = clamp(pos_y_reg, q_data.move_y, eff_limit(screen_height));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            held_reg     <= '0;
            pos_x_reg    <= RESET_X;
            pos_y_reg    <= RESET_Y;
        end else begin
            if (q_pop) begin
                m_tvalid_reg <= 1'b1;
                held_reg     <= held_next;
                pos_x_reg    <= pos_x_next;
                pos_y_reg    <= pos_y_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (q_pop) begin
            cx_reg      <= pos_x_next;
            cy_reg      <= pos_y_next;
            mx_reg      <= q_data.move_x;
            my_reg      <= q_data.move_y;
            o_held_reg  <= held_next;
            o_press_reg <= held_next & ~held_reg;
            o_rel_reg   <= held_reg & ~held_next;
            wv_reg      <= q_data.wheel_v;
            wh_reg      <= q_data.wheel_h;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({wh_reg, wv_reg, o_rel_reg, o_press_reg, o_held_reg,
                                    my_reg, mx_reg, cy_reg, cx_reg});

    a_press_release_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((o_press_reg & o_rel_reg) == 5'd0))
        else $error("button both pressed and released");

    a_held_tracks_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (o_held_reg == held_reg))
        else $error("held state differs from last result");

    a_pressed_are_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((o_press_reg & ~o_held_reg) == 5'd0))
        else $error("pressed button not held");

endmodule

>>> hdl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder: configuration registers and
// the front / queue / back chain. Depends on ps2md_pkg and the ps2md_* modules.
//
// Usage:
//  - s_ channel: one PS/2 byte per beat in s_tdata[7:0]. Packets are 3 bytes
//    (format 0) or 4 bytes (formats 1 and 2). Bad first bytes are skipped.
//  - m_ channel: one beat per decoded packet carrying cursor position, move,
//    button held/pressed/released flags and wheel steps. Dropped packets and
//    format 3 give no beat.
//  - cfg_: write enable, register index and data; writes take effect at the
//    next edge. Change them only while no packet is in flight.
//  - Throughput: one byte per cycle while s_tready is high. The front assembler
//    takes a byte every cycle unless the queue is full; the back unit retires one
//    packet per cycle while m_ is not stalled (one add and clamp compare per axis).
//  - Path: the last byte of a packet writes its record into the queue; the back
//    unit then pops it and registers the result beat shown on m_.
//  - Stall: while m_tready is low the result stays in the output register;
//    the two-entry queue absorbs further packets, and s_tready drops only
//    when the queue is full.
//  - Reset (synchronous, aresetn low): format 0, 1024 x 768 screen, cursor at
//    screen center, no buttons held, queue and output empty.
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // from bit 0 up: cursor_x, cursor_y, move_x, move_y, buttons_held,
    // buttons_pressed, buttons_released, wheel_vertical, wheel_horizontal, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    fmt_t             format_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic s_accept;
    logic push;
    pkt_t push_rec;
    logic q_full;
    logic q_pop;
    logic q_valid;
    pkt_t q_rec;

    // Configuration registers; index 3 is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_STD;
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FORMAT: format_reg <= fmt_t'(cfg_data[1:0]);
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only a completing byte pushes, but gating every byte on queue space
    // keeps the front simple and costs nothing at the input rate.
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    ps2md_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_byte (s_tdata[7:0]),
        .fmt       (format_reg),
        .push      (push),
        .rec       (push_rec)
    );

    ps2md_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rec)
    );

    ps2md_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .q_valid       (q_valid),
        .q_data        (q_rec),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ps2_mouse_packet_decoder: byte stream in, one report beat per packet.
// Depends on ps2md_pkg and the decoder RTL; carries its own cycle-free model of the decoder.
module testbench;
    import ps2md_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int STALL_LIMIT = 3000;  // cycles with no beat on either side
    localparam int SETTLE      = 4;     // covers the queue and output register, plus margin

    // one report beat as packed on m_tdata, last field in the low bits
    typedef struct packed {
        logic signed [1:0]      wheel_h;
        logic signed [1:0]      wheel_v;
        logic [4:0]             released;
        logic [4:0]             pressed;
        logic [4:0]             held;
        logic signed [9:0]      move_y;
        logic signed [8:0]      move_x;
        logic [COORD_BITS-1:0]  cursor_y;
        logic [COORD_BITS-1:0]  cursor_x;
    } mouse_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // from bit 0 up: cursor_x, cursor_y, move_x, move_y, buttons_held,
    // buttons_pressed, buttons_released, wheel_vertical, wheel_horizontal, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    ps2_mouse_packet_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Decoder model: mirrors the configuration and packet state
    // ------------------------------------------------------------------
    fmt_t             mode_fmt;
    logic [CFG_W-1:0] limit_w;
    logic [CFG_W-1:0] limit_h;
    logic [1:0]       byte_idx;
    logic [7:0]       pkt_buf [3];
    logic [4:0]       btn_state;
    int               cur_x;
    int               cur_y;

    mouse_report_t pending_reports[$];   // reports still owed by the DUT

    int  mismatch_count = 0;
    int  n_bytes_sent   = 0;
    int  n_reports_seen = 0;
    bit  idle_on        = 1'b1;   // random gaps on both sides
    bit  hold_request   = 1'b0;   // asks the receiver for a long hold-off

    // out-of-range limits: 0 behaves as 1, anything above 2**COORD_BITS saturates
    function automatic int clamp_axis_pos(int pos, int mv, logic [CFG_W-1:0] limit);
        int lim;
        int v;
        lim = limit;
        if (lim < 1) lim = 1;
        if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
        v = pos + mv;
        if (v < 0) v = 0;
        else if (v >= lim) v = lim - 1;
        return v;
    endfunction

    // close out a packet: update buttons and cursor, build the report
    function automatic mouse_report_t make_report(logic [7:0] y_byte, logic [1:0] high_btn,
                                                  logic [1:0] wv, logic [1:0] wh);
        logic [4:0]    now_held;
        int            mx;
        int            my;
        mouse_report_t r;
        // byte0 order is left, right, middle; report order is left, middle, right
        now_held = {high_btn, pkt_buf[0][1], pkt_buf[0][2], pkt_buf[0][0]};
        mx = pkt_buf[0][4] ? int'(pkt_buf[1]) - 256 : int'(pkt_buf[1]);
        my = pkt_buf[0][5] ? int'(y_byte) - 256 : int'(y_byte);
        my = -my;   // PS/2 Y is up-positive, screen Y is down-positive
        r.held     = now_held;
        r.pressed  = now_held & ~btn_state;
        r.released = btn_state & ~now_held;
        btn_state  = now_held;
        cur_x = clamp_axis_pos(cur_x, mx, limit_w);
        cur_y = clamp_axis_pos(cur_y, my, limit_h);
        r.cursor_x = cur_x[COORD_BITS-1:0];
        r.cursor_y = cur_y[COORD_BITS-1:0];
        r.move_x   = mx[8:0];
        r.move_y   = my[9:0];
        r.wheel_v  = wv;
        r.wheel_h  = wh;
        return r;
    endfunction

    // feed one accepted byte; returns 1 when it completes a reported packet
    function automatic bit decode_byte(input logic [7:0] b, output mouse_report_t r);
        logic [1:0] wv;
        logic [1:0] wh;
        wv = WHEEL_ZERO;
        wh = WHEEL_ZERO;
        r  = '0;
        if (mode_fmt == FMT_NONE) begin
            byte_idx = 2'd0;
            return 1'b0;
        end
        if (byte_idx == 2'd0) begin
            // header must have bit 3 set and both overflow bits clear
            if ((b & HDR_MASK) != HDR_MATCH) return 1'b0;
            pkt_buf[0] = b;
            byte_idx = 2'd1;
            return 1'b0;
        end
        if (byte_idx == 2'd1) begin
            pkt_buf[1] = b;
            byte_idx = 2'd2;
            return 1'b0;
        end
        if (mode_fmt == FMT_STD) begin
            // also reached at count 3 after a switch from a 4-byte format
            pkt_buf[2] = b;
            byte_idx = 2'd0;
            r = make_report(b, btn_state[4:3], WHEEL_ZERO, WHEEL_ZERO);
            return 1'b1;
        end
        if (byte_idx == 2'd2) begin
            pkt_buf[2] = b;
            byte_idx = 2'd3;
            return 1'b0;
        end
        byte_idx = 2'd0;
        if (mode_fmt == FMT_WHEEL) begin
            // zero wheel byte means no step
            if (b != 8'd0) wv = b[7] ? WHEEL_NEG : WHEEL_POS;
            r = make_report(pkt_buf[2], btn_state[4:3], wv, WHEEL_ZERO);
            return 1'b1;
        end
        // five-button: top bits or an unknown nibble drop the packet untouched
        if (b[7:6] != 2'b00) return 1'b0;
        case (b[3:0])
            NIB_NONE: ;
            NIB_UP: wv = WHEEL_POS;
            NIB_DOWN: wv = WHEEL_NEG;
            NIB_RIGHT: wh = WHEEL_POS;
            NIB_LEFT: wh = WHEEL_NEG;
            default: return 1'b0;
        endcase
        r = make_report(pkt_buf[2], {b[5], b[4]}, wv, wh);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // One byte beat. s_tvalid stays high after acceptance so back-to-back
    // bytes need no extra assignment; random gaps lower it before a byte.
    task automatic send_byte(input logic [7:0] b);
        mouse_report_t rep;
        while (idle_on && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        n_bytes_sent++;
        if (decode_byte(b, rep)) pending_reports.push_back(rep);
    endtask

    // Quiet the input and let every owed report come out. Dropped packets
    // leave nothing to wait for, so a SETTLE wait follows.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_FORMAT: mode_fmt = fmt_t'(val[1:0]);
            REG_WIDTH:  limit_w  = val;
            REG_HEIGHT: limit_h  = val;
            default: ;
        endcase
    endtask

    // all three registers, only with the pipeline empty
    task automatic configure(input fmt_t f, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] h);
        drain_stream();
        write_reg(REG_FORMAT, CFG_W'(f));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    // screen limits weighted toward the extremes, 0 and 8191 included
    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(5))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(4096);
            3: return CFG_W'(8191);
            4: return CFG_W'($urandom_range(2, 64));
            default: return CFG_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // Mostly well-formed packets with random content; some noise bytes and
    // corrupted headers to knock the byte count out of step.
    task automatic send_random_packet(input fmt_t f);
        int         roll;
        logic [7:0] b0;
        logic [7:0] b3;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        b0 = 8'($urandom_range(255));
        b0[3] = 1'b1;
        b0[7:6] = (roll < 15) ? 2'($urandom_range(1, 3)) : 2'b00;
        send_byte(b0);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        if (f == FMT_WHEEL) begin
            b3 = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
            send_byte(b3);
        end else if (f == FMT_FIVE) begin
            b3 = 8'($urandom_range(255));
            case ($urandom_range(5))
                0: b3[3:0] = NIB_NONE;
                1: b3[3:0] = NIB_UP;
                2: b3[3:0] = NIB_DOWN;
                3: b3[3:0] = NIB_RIGHT;
                4: b3[3:0] = NIB_LEFT;
                default: ;   // any nibble, mostly invalid
            endcase
            if ($urandom_range(99) >= 8) b3[7:6] = 2'b00;
            send_byte(b3);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= !idle_on || ($urandom_range(99) >= 29);
            end
        end
    end

    // ------------------------------------------------------------------
    // Report checker: every beat against the oldest owed report
    // ------------------------------------------------------------------
    mouse_report_t got_rep;
    mouse_report_t want_rep;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rep = m_tdata[OUT_BITS-1:0];
            n_reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("report beat with nothing owed: %h", m_tdata);
                mismatch_count++;
            end else begin
                want_rep = pending_reports.pop_front();
                check_field("cursor_x", want_rep.cursor_x, got_rep.cursor_x);
                check_field("cursor_y", want_rep.cursor_y, got_rep.cursor_y);
                check_field("move_x", want_rep.move_x, got_rep.move_x);
                check_field("move_y", want_rep.move_y, got_rep.move_y);
                check_field("buttons_held", want_rep.held, got_rep.held);
                check_field("buttons_pressed", want_rep.pressed, got_rep.pressed);
                check_field("buttons_released", want_rep.released, got_rep.released);
                check_field("wheel_vertical", want_rep.wheel_v, got_rep.wheel_v);
                check_field("wheel_horizontal", want_rep.wheel_h, got_rep.wheel_h);
            end
        end
    end

    // Watchdog: too long with no beat on either channel ends the run
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset defaults: format 0, 1024 x 768, cursor centered
    task automatic test_standard_packets();
        // bit 3 clear, then each overflow bit: all dropped
        send_byte(8'h00);
        send_byte(8'h48);
        send_byte(8'h88);
        // all three buttons, both signs, most negative moves
        send_byte(8'h3F);
        send_byte(8'h00);
        send_byte(8'h00);
        // most positive moves, all buttons released
        send_byte(8'h08);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    // wheel format on a 1 x 1 screen: cursor pinned at 0
    task automatic test_wheel_packets();
        configure(FMT_WHEEL, CFG_W'(1), CFG_W'(1));
        send_byte(8'h09);
        send_byte(8'h10);
        send_byte(8'h10);
        send_byte(8'h00);   // zero wheel byte -> no step
        send_byte(8'h0C);
        send_byte(8'hF0);
        send_byte(8'h05);
        send_byte(8'h80);   // negative wheel byte
    endtask

    // five-button format; width above range, height 0
    task automatic test_five_button_packets();
        configure(FMT_FIVE, CFG_W'(8191), CFG_W'(0));
        send_byte(8'h08);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte({2'b00, 2'b11, NIB_UP});    // fourth and fifth down
        send_byte(8'h0A);
        send_byte(8'h40);
        send_byte(8'h40);
        send_byte(8'h05);                     // bad nibble: dropped, no state change
        send_byte(8'h09);
        send_byte(8'h40);
        send_byte(8'h40);
        send_byte(8'h41);                     // bit 6 set: dropped
        send_byte(8'h08);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte({2'b00, 2'b00, NIB_LEFT});  // fourth and fifth released
    endtask

    // format changes with a packet half-assembled, and the disabled format
    task automatic test_format_switch();
        configure(FMT_WHEEL, CFG_W'(1024), CFG_W'(768));
        send_byte(8'h08);
        send_byte(8'h05);
        send_byte(8'h06);
        configure(FMT_STD, CFG_W'(1024), CFG_W'(768));
        send_byte(8'h07);   // count 3 in format 0 ends the packet
        send_byte(8'h09);
        send_byte(8'h01);
        configure(FMT_FIVE, CFG_W'(1024), CFG_W'(768));
        send_byte(8'h02);
        send_byte({2'b00, 2'b01, NIB_RIGHT});
        send_byte(8'h08);
        configure(FMT_NONE, CFG_W'(1024), CFG_W'(768));
        send_byte(8'h08);   // discarded, count cleared
        send_byte(8'h10);
        configure(FMT_STD, CFG_W'(1024), CFG_W'(768));
        send_byte(8'h10);   // not a header after the clear
    endtask

    // receiver holds off long enough for the queue to fill and s_tready to drop
    task automatic test_backpressure();
        configure(FMT_STD, CFG_W'(4096), CFG_W'(4096));
        hold_request = 1'b1;
        repeat (25) send_random_packet(FMT_STD);
    endtask

    // random phases with random configuration; one phase runs with no gaps
    task automatic test_random_traffic(input int n_target);
        int   budget;
        int   phase;
        int   sent_before;
        fmt_t f;
        budget = n_target;
        phase = 0;
        while (budget > 0) begin
            f = fmt_t'($urandom_range(0, 2));
            if (phase % 7 == 6) f = FMT_NONE;
            idle_on = (phase != 4);
            configure(f, pick_limit(), pick_limit());
            sent_before = n_bytes_sent;
            if (f == FMT_NONE) begin
                // ignored bytes do not count against the budget
                repeat (12) send_byte(8'($urandom_range(255)));
            end else begin
                while (n_bytes_sent - sent_before < 160) send_random_packet(f);
                budget -= n_bytes_sent - sent_before;
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // model state after reset
        mode_fmt  = FMT_STD;
        limit_w   = RESET_WIDTH;
        limit_h   = RESET_HEIGHT;
        byte_idx  = 2'd0;
        btn_state = 5'd0;
        cur_x     = int'(RESET_WIDTH) / 2;
        cur_y     = int'(RESET_HEIGHT) / 2;
        foreach (pkt_buf[i]) pkt_buf[i] = 8'd0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_standard_packets();
        test_wheel_packets();
        test_five_button_packets();
        test_format_switch();
        test_backpressure();
        test_random_traffic(2000);

        drain_stream();
        repeat (8) @(posedge aclk);

        $display("tb: %0d bytes sent, %0d report beats checked", n_bytes_sent, n_reports_seen);
        $display("tb: covered all three packet formats, disabled format, limit extremes, stalls");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> ps2_mouse_packet_decoder.f
hdl/ps2md_pkg.sv
hdl/ps2md_front.sv
hdl/ps2md_queue.sv
hdl/ps2md_back.sv
hdl/ps2_mouse_packet_decoder.sv
sim/testbench.sv
